### hw/rtl/assert_macros.svh
// assertion macros used by the encoder top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, ignored while reset is held
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property, also checked during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rlme_pkg.sv
// constants and types for the run length marker encoder
`default_nettype none

package rlme_pkg;

    localparam int BYTE_W = 8;
    localparam int RUN_W = 4;
    localparam int MAX_BEATS = 4;
    localparam int BEAT_CNT_W = 3;
    localparam int SLOT_IDX_W = 2;

    localparam logic [RUN_W-1:0] MAX_RUN = RUN_W'(9);
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] MARKER_RESET = 8'h23;

    // one encoded beat as it waits in the output queue
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_step;
        logic              message_done;
    } beat_t;

endpackage

`default_nettype wire

### hw/rtl/run_length_marker_encoder_top.sv
// run length marker encoder: input decode, run tracking and output beat queue
// results of an input beat reach the master side in the cycle after acceptance
// throughput: one input beat per cycle if it closes no run or yields one beat and m_tready
// is high; else one cycle per output beat (up to 4), set by the one-byte output channel
// reset: aresetn synchronous active low; clears the open run, the queue and sets marker to '#'
`default_nettype none
`include "assert_macros.svh"

module run_length_marker_encoder_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration write: marker byte
    input  wire logic                       cfg_wr_en,
    input  wire logic [rlme_pkg::BYTE_W-1:0] cfg_wr_data,
    // slave side
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [rlme_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic                       s_tlast,    // end_of_message
    // master side
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [rlme_pkg::BYTE_W-1:0]     m_tdata,    // [7:0] out_byte
    output logic                            m_tuser,    // [0] last_of_step
    output logic                            m_tlast     // message_done
);

    import rlme_pkg::*;

    // run state and configuration
    logic [BYTE_W-1:0]     marker_reg;
    logic [BYTE_W-1:0]     held_reg, held_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic                  pend_reg, pend_next;

    // output beat queue, head always at slot 0
    beat_t                 slot_reg [MAX_BEATS];
    beat_t                 slot_new [MAX_BEATS];
    logic [BEAT_CNT_W-1:0] cnt_reg;
    logic [BEAT_CNT_W-1:0] n_new;

    logic s_accept;
    logic m_accept;
    logic extend;
    logic flush_open;
    logic [BYTE_W-1:0] run2_byte;
    logic [RUN_W-1:0]  run2_len;
    logic [BEAT_CNT_W-1:0] k;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = slot_reg[0].out_byte;
    assign m_tuser  = slot_reg[0].last_of_step;
    assign m_tlast  = slot_reg[0].message_done;
    assign m_accept = m_tvalid && m_tready;

    // take a new beat when the queue is empty or drains its last beat now
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == BEAT_CNT_W'(1)) && m_tready);
    assign s_accept = s_tvalid && s_tready;

    // same byte grows the open run until it hits the split length
    assign extend     = pend_reg && (s_tdata == held_reg) && (run_reg < MAX_RUN);
    assign flush_open = pend_reg && !extend;

    // run that is open after this beat
    assign run2_byte = extend ? held_reg : s_tdata;
    assign run2_len  = extend ? run_reg + RUN_W'(1) : RUN_W'(1);

    always_comb begin
        for (int i = 0; i < MAX_BEATS; i++) begin
            slot_new[i] = '0;
        end
        k = '0;
        // close the previous run when this byte does not extend it
        if (flush_open) begin
            if (run_reg >= RUN_W'(2)) begin
                slot_new[0].out_byte = marker_reg;
                slot_new[1].out_byte = held_reg;
                slot_new[2].out_byte = DIGIT_ZERO + BYTE_W'(run_reg);
                k = BEAT_CNT_W'(3);
            end else begin
                slot_new[0].out_byte = held_reg;
                k = BEAT_CNT_W'(1);
            end
        end
        n_new = k;
        // end of message closes the open run too; after a flush it is always a single byte
        if (s_tlast) begin
            if ((k == '0) && (run2_len >= RUN_W'(2))) begin
                slot_new[0].out_byte = marker_reg;
                slot_new[1].out_byte = run2_byte;
                slot_new[2].out_byte = DIGIT_ZERO + BYTE_W'(run2_len);
                n_new = BEAT_CNT_W'(3);
            end else begin
                slot_new[k[SLOT_IDX_W-1:0]].out_byte = run2_byte;
                n_new = k + BEAT_CNT_W'(1);
            end
        end
        if (n_new != '0) begin
            slot_new[SLOT_IDX_W'(n_new - BEAT_CNT_W'(1))].last_of_step = 1'b1;
            slot_new[SLOT_IDX_W'(n_new - BEAT_CNT_W'(1))].message_done = s_tlast;
        end
    end

    always_comb begin
        held_next = held_reg;
        run_next  = run_reg;
        pend_next = pend_reg;
        if (s_accept) begin
            if (s_tlast) begin
                held_next = '0;
                run_next  = '0;
                pend_next = 1'b0;
            end else begin
                held_next = run2_byte;
                run_next  = run2_len;
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= MARKER_RESET;
            held_reg   <= '0;
            run_reg    <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                marker_reg <= cfg_wr_data;
            end
            held_reg <= held_next;
            run_reg  <= run_next;
            pend_reg <= pend_next;
            if (s_accept) begin
                cnt_reg <= n_new;
            end else if (m_accept) begin
                cnt_reg <= cnt_reg - BEAT_CNT_W'(1);
            end
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_BEATS; i++) begin
                slot_reg[i] <= slot_new[i];
            end
        end else if (m_accept) begin
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    `ASSERT_CLKD(a_cnt_bound, aclk, aresetn,
        cnt_reg <= BEAT_CNT_W'(MAX_BEATS), "queue count overflow")
    `ASSERT_CLKD(a_done_ends_step, aclk, aresetn,
        (m_tvalid && m_tlast) |-> m_tuser, "message_done without last_of_step")
    `ASSERT_CLKD(a_eom_clears, aclk, aresetn,
        (s_accept && s_tlast) |=> (!pend_reg && m_tvalid),
        "end of message left run open or gave no beat")
    `ASSERT_CLKD(a_run_range, aclk, aresetn,
        (pend_reg ? (run_reg != '0 && run_reg <= MAX_RUN) : (run_reg == '0)),
        "run length out of range")

endmodule

`default_nettype wire
